// ----- rtl/lmps_pkg.sv -----
package lmps_pkg;

  localparam int unsigned RATE_CAP = 100000;

  typedef enum logic [2:0] {
    CFG_ACTIVE   = 3'd0,
    CFG_COUNT    = 3'd1,
    CFG_NORMAL   = 3'd2,
    CFG_INTERVAL = 3'd3,
    CFG_SPEED    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_NORMAL   = 2'd1,
    KIND_INTERVAL = 2'd2,
    KIND_SPEED    = 2'd3
  } entry_kind_t;

  typedef enum logic [1:0] {
    OUT_NORMAL   = 2'd0,
    OUT_INTERVAL = 2'd1,
    OUT_SPEED    = 2'd2
  } out_kind_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1
  } cmd_code_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RESTART,
    ST_TICK,
    ST_WRAP,
    ST_SEARCH,
    ST_ENTER,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [15:0] time_step;
    logic [3:0]  entry_index;
    logic [1:0]  entry_kind;
    logic [15:0] entry_target;
    logic [15:0] entry_duration;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  command_kind;
    logic [15:0] target_position;
    logic [15:0] interval_ms;
    logic [16:0] speed_rate;
    logic [3:0]  pattern_index;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic wr_entry;  // write selected slot
    logic restart;   // one start-time step, advance pointer
    logic tick_add;  // add delta, compute total
    logic wrap;      // one remainder step for modulo
    logic search;    // one search step
    logic enter;     // step to next entry
    logic mul;       // form numerator and denominator
    logic div;       // one divide step
    logic emit;      // drive result strobe
    logic snap;      // store loop time, no change
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_write;
    logic write_ok;
    logic restart_done;
    logic wrap_done;
    logic search_done;
    logic changed;
    logic is_speed;
    logic emits;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/lmps_ctrl.sv -----
module lmps_ctrl
  import lmps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic active,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (sts.is_write) begin
          if (sts.write_ok) begin
            ctl.wr_entry = 1'b1;
            state_nxt = ST_RESTART;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (active) begin
          state_nxt = ST_TICK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESTART: begin
        ctl.restart = 1'b1;
        if (sts.restart_done) state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        ctl.tick_add = 1'b1;
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        ctl.wrap = 1'b1;
        if (sts.wrap_done) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        ctl.search = 1'b1;
        if (sts.search_done) state_nxt = ST_ENTER;
      end
      ST_ENTER: begin
        if (sts.changed) begin
          ctl.enter = 1'b1;
          if (!sts.emits) state_nxt = ST_IDLE;
          else if (sts.is_speed) state_nxt = ST_MUL;
          else state_nxt = ST_EMIT;
        end else begin
          ctl.snap = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        ctl.mul = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        ctl.div = 1'b1;
        if (sts.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        ctl.emit = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/lmps_dpath.sv -----
module lmps_dpath
  import lmps_pkg::*;
#(
  parameter int MAX_PATTERNS = 16,
  parameter int TARGET_FULL_SCALE = 65535
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  logic [4:0] count_cfg,
  input  logic      normal_en,
  input  logic      interval_en,
  input  logic      speed_en,
  input  ctl_t      ctl,
  output sts_t      sts,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int IW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int CW = $clog2(MAX_PATTERNS + 1);
  localparam int TW = 17 + IW;             // start times and loop time
  localparam int NW = 35;                  // 2*d*100000 + F*D
  localparam int DW = 34;                  // 2*F*D
  localparam int DIV_STEPS = NW;

  // table held in flip-flops, read at the walking pointer and the entry slots
  logic [1:0]    kind_r  [MAX_PATTERNS];
  logic [15:0]   tgt_r   [MAX_PATTERNS];
  logic [15:0]   dur_r   [MAX_PATTERNS];
  logic [TW-1:0] start_r [MAX_PATTERNS];

  in_word_t      in_r;
  logic [TW-1:0] loop_r, t_r;
  logic [TW-1:0] total_r;
  logic [IW-1:0] cur_r;
  logic [CW-1:0] ptr_r;          // shared walking pointer
  logic [IW-1:0] next_r, prev_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] quo_r;
  logic [DW:0]   rem_r;
  logic [5:0]    dstep_r;
  logic          force_r;        // single entry passed the end

  function automatic logic [CW-1:0] mod_n(logic [IW-1:0] a, logic [CW-1:0] m);
    logic [CW:0] r;
    r = '0;
    for (int b = IW - 1; b >= 0; b--) begin
      r = {r[CW-1:0], a[b]};
      if (r >= {1'b0, m}) r = r - {1'b0, m};
    end
    return r[CW-1:0];
  endfunction

  logic [CW-1:0] n;
  always_comb begin
    if (count_cfg == '0) n = CW'(1);
    else if (32'(count_cfg) > MAX_PATTERNS) n = CW'(MAX_PATTERNS);
    else n = count_cfg[CW-1:0];
  end

  logic [IW-1:0] last_idx, ptr_idx;
  assign last_idx = IW'(n - CW'(1));
  assign ptr_idx  = ptr_r[IW-1:0];

  logic [TW-1:0] end_ptr, end_last;
  assign end_ptr  = start_r[ptr_idx] + TW'(dur_r[ptr_idx]);
  assign end_last = start_r[last_idx] + TW'(dur_r[last_idx]);

  logic [CW-1:0] cur_mod, cur_inc;
  logic [IW-1:0] nxt_idx;
  assign cur_mod = mod_n(cur_r, n);
  assign cur_inc = (cur_mod + CW'(1) >= n) ? '0 : cur_mod + CW'(1);
  assign nxt_idx = cur_inc[IW-1:0];

  logic [1:0] nk;
  logic       emits_c;
  assign nk = kind_r[nxt_idx];
  always_comb begin
    case (nk)
      KIND_NORMAL:   emits_c = normal_en;
      KIND_INTERVAL: emits_c = interval_en;
      KIND_SPEED:    emits_c = speed_en;
      default:       emits_c = 1'b0;
    endcase
  end

  logic [15:0] dabs;
  assign dabs = (tgt_r[prev_r] > tgt_r[next_r]) ? tgt_r[prev_r] - tgt_r[next_r]
                                                : tgt_r[next_r] - tgt_r[prev_r];

  logic [DW:0] rem_sh;
  assign rem_sh = {rem_r[DW-1:0], num_r[NW-1]};

  logic [TW:0] wrap_sh, wrap_rem;
  assign wrap_sh  = {rem_r[TW-1:0], t_r[TW-1]};
  assign wrap_rem = (wrap_sh >= {1'b0, total_r}) ? wrap_sh - {1'b0, total_r} : wrap_sh;

  always_comb begin
    sts.is_write     = in_r.cmd[0];
    sts.write_ok     = CW'(in_r.entry_index) < n;
    sts.restart_done = (ptr_r >= CW'(MAX_PATTERNS - 1));
    sts.wrap_done    = (dstep_r == 6'(TW - 1));
    sts.search_done  = !((ptr_r + CW'(1) < n) && (end_ptr <= t_r));
    sts.changed      = force_r || (ptr_idx != cur_r);
    sts.is_speed     = (nk == KIND_SPEED);
    sts.emits        = emits_c;
    sts.div_done     = (dstep_r == 6'(DIV_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATTERNS; i++) begin
        kind_r[i]  <= KIND_NONE;
        tgt_r[i]   <= '0;
        dur_r[i]   <= 16'd1;
        start_r[i] <= TW'(i);
      end
      loop_r    <= '0;
      cur_r     <= '0;
      out_valid <= 1'b0;
      ptr_r     <= '0;
    end else begin
      out_valid <= ctl.emit;
      if (ctl.load) in_r <= in_word;
      if (ctl.wr_entry) begin
        kind_r[in_r.entry_index[IW-1:0]] <= in_r.entry_kind;
        tgt_r[in_r.entry_index[IW-1:0]]  <= in_r.entry_target;
        dur_r[in_r.entry_index[IW-1:0]]  <=
          (in_r.entry_duration == '0) ? 16'd1 : in_r.entry_duration;
        ptr_r <= CW'(in_r.entry_index);
      end
      if (ctl.restart && !sts.restart_done) begin
        // ripple start times one slot per cycle
        start_r[IW'(ptr_r + CW'(1))] <= end_ptr;
        ptr_r <= ptr_r + CW'(1);
      end
      if (ctl.tick_add) begin
        t_r     <= loop_r + TW'(in_r.time_step);
        total_r <= end_last;
        force_r <= (n == CW'(1)) && (loop_r + TW'(in_r.time_step) >= end_last);
        ptr_r   <= '0;
        rem_r   <= '0;
        dstep_r <= '0;
      end
      if (ctl.wrap) begin
        // restoring remainder by the total, one bit of the sum per cycle
        rem_r   <= {{(DW - TW){1'b0}}, wrap_rem};
        dstep_r <= dstep_r + 6'd1;
        if (sts.wrap_done) t_r <= wrap_rem[TW-1:0];
        else t_r <= {t_r[TW-2:0], 1'b0};
      end
      if (ctl.search && !sts.search_done) ptr_r <= ptr_r + CW'(1);
      if (ctl.snap) loop_r <= t_r;
      if (ctl.enter) begin
        loop_r <= start_r[nxt_idx];
        cur_r  <= nxt_idx;
        next_r <= nxt_idx;
        prev_r <= cur_mod[IW-1:0];
        out_word.pattern_index   <= 4'(nxt_idx);
        out_word.target_position <= tgt_r[nxt_idx];
        out_word.interval_ms     <= (nk == KIND_INTERVAL) ? dur_r[nxt_idx] : '0;
        out_word.speed_rate      <= '0;
        case (nk)
          KIND_INTERVAL: out_word.command_kind <= OUT_INTERVAL;
          KIND_SPEED:    out_word.command_kind <= OUT_SPEED;
          default:       out_word.command_kind <= OUT_NORMAL;
        endcase
      end
      if (ctl.mul) begin
        num_r   <= NW'(dabs) * NW'(200000) +
                   NW'(TARGET_FULL_SCALE) * NW'(dur_r[next_r]);
        den_r   <= DW'(35'(2 * TARGET_FULL_SCALE) * 35'(dur_r[next_r]));
        rem_r   <= '0;
        quo_r   <= '0;
        dstep_r <= '0;
      end
      if (ctl.div) begin
        // restoring division, one quotient bit per cycle
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= rem_sh - {1'b0, den_r};
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
        num_r   <= {num_r[NW-2:0], 1'b0};
        dstep_r <= dstep_r + 6'd1;
      end
      if (ctl.emit) begin
        if (out_word.command_kind == OUT_SPEED) begin
          if (quo_r == '0) out_word.speed_rate <= 17'd1;
          else if (quo_r > NW'(RATE_CAP)) out_word.speed_rate <= 17'(RATE_CAP);
          else out_word.speed_rate <= quo_r[16:0];
        end
      end
    end
  end

endmodule

// ----- rtl/looping_motion_pattern_sequencer.sv -----
// Looping motion pattern sequencer. Pulse start with an in_word while busy is low;
// one word is taken per start. A write holds busy through the start-time ripple,
// one slot per cycle; a write past the count in use and a tick while inactive
// end without effect. An active tick takes a remainder of the loop time by the
// total, one bit per cycle, then a linear search one entry per cycle. A speed
// command then goes through the 35-step divider. A result appears on out_word for
// one cycle with out_valid high, in the cycle busy drops; it cannot be held off.
module looping_motion_pattern_sequencer
  import lmps_pkg::*;
#(
  parameter int MAX_PATTERNS = 16,
  parameter int TARGET_FULL_SCALE = 65535
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_data
);

  logic       active_r, normal_r, interval_r, speed_r;
  logic [4:0] count_r;
  ctl_t       ctl;
  sts_t       sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      count_r    <= 5'd1;
      normal_r   <= 1'b1;
      interval_r <= 1'b1;
      speed_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE:   active_r   <= cfg_data[0];
        CFG_COUNT:    count_r    <= cfg_data;
        CFG_NORMAL:   normal_r   <= cfg_data[0];
        CFG_INTERVAL: interval_r <= cfg_data[0];
        CFG_SPEED:    speed_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lmps_ctrl u_ctrl (
    .clk, .rst_n, .start, .active(active_r), .sts, .ctl, .busy
  );

  lmps_dpath #(
    .MAX_PATTERNS(MAX_PATTERNS), .TARGET_FULL_SCALE(TARGET_FULL_SCALE)
  ) u_dpath (
    .clk, .rst_n, .in_word, .count_cfg(count_r), .normal_en(normal_r),
    .interval_en(interval_r), .speed_en(speed_r), .ctl, .sts,
    .out_valid, .out_word
  );

endmodule

// ----- rtl/lmps_checker.sv -----
module lmps_checker
  import lmps_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.command_kind != 2'd3) else $error("bad kind");
  a_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.command_kind == OUT_SPEED |->
      out_word.speed_rate != '0 && out_word.interval_ms == '0)
    else $error("bad speed word");
  a_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.command_kind == OUT_NORMAL |->
      out_word.speed_rate == '0 && out_word.interval_ms == '0)
    else $error("bad normal word");

endmodule

bind looping_motion_pattern_sequencer lmps_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_word
);

// ----- bench/looping_motion_pattern_sequencer_chk.sv -----
module looping_motion_pattern_sequencer_chk
  import lmps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_word_t   in_word,
  input  logic       out_valid,
  input  out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_data,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam longint FULL_SCALE = 65535;

  logic        run_en;
  logic [4:0]  slot_count;
  logic        normal_ok, interval_ok, speed_ok;

  logic [1:0]  slot_kind [NSLOT];
  logic [15:0] slot_target [NSLOT];
  logic [15:0] slot_dur [NSLOT];
  int unsigned slot_start [NSLOT];
  int unsigned loop_pos;
  int unsigned cur_slot;

  out_word_t cmd_q[$];

  assign pending = cmd_q.size();

  function automatic int unsigned slots_in_use();
    if (slot_count == 0) return 1;
    if (slot_count > NSLOT) return NSLOT;
    return slot_count;
  endfunction

  function automatic int unsigned slot_end(int unsigned i);
    return slot_start[i] + slot_dur[i];
  endfunction

  function automatic logic [16:0] rate_of(logic [15:0] from_t, logic [15:0] to_t,
                                          logic [15:0] dur);
    longint d, den, r;
    d = (from_t > to_t) ? longint'(from_t - to_t) : longint'(to_t - from_t);
    den = FULL_SCALE * longint'(dur);
    r = (2 * d * 100000 + den) / (2 * den);
    if (r < 1) r = 1;
    if (r > RATE_CAP) r = RATE_CAP;
    return 17'(r);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic apply_word(in_word_t w);
    int unsigned n, total, t, cur, found, nxt, prv;
    out_word_t r;
    logic hit;
    n = slots_in_use();
    if (w.cmd == 1'(CMD_WRITE)) begin
      if (w.entry_index >= n) return;
      slot_kind[w.entry_index] = w.entry_kind;
      slot_target[w.entry_index] = w.entry_target;
      slot_dur[w.entry_index] = (w.entry_duration == 0) ? 16'd1 : w.entry_duration;
      for (int j = w.entry_index + 1; j < NSLOT; j++) slot_start[j] = slot_end(j - 1);
      return;
    end
    if (!run_en) return;
    total = slot_end(n - 1);
    t = loop_pos + w.time_step;
    cur = cur_slot;
    found = 0;
    if (n == 1 && t >= total) cur = n;
    t = t % total;
    while (found + 1 < n && slot_end(found) <= t) found++;
    if (found != cur) begin
      nxt = (cur + 1) % n;
      prv = cur % n;
      t = slot_start[nxt];
      r = '0;
      r.target_position = slot_target[nxt];
      r.pattern_index = 4'(nxt);
      hit = 1'b0;
      case (entry_kind_t'(slot_kind[nxt]))
        KIND_NORMAL: if (normal_ok) begin
          hit = 1'b1;
          r.command_kind = OUT_NORMAL;
        end
        KIND_INTERVAL: if (interval_ok) begin
          hit = 1'b1;
          r.command_kind = OUT_INTERVAL;
          r.interval_ms = slot_dur[nxt];
        end
        KIND_SPEED: if (speed_ok) begin
          hit = 1'b1;
          r.command_kind = OUT_SPEED;
          r.speed_rate = rate_of(slot_target[prv], slot_target[nxt], slot_dur[nxt]);
        end
        default: ;
      endcase
      if (hit) cmd_q.push_back(r);
      cur_slot = nxt;
    end
    loop_pos = t;
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      run_en <= 1'b0;
      slot_count <= 5'd1;
      normal_ok <= 1'b1;
      interval_ok <= 1'b1;
      speed_ok <= 1'b1;
      for (int i = 0; i < NSLOT; i++) begin
        slot_kind[i] = KIND_NONE;
        slot_target[i] = '0;
        slot_dur[i] = 16'd1;
        slot_start[i] = i;
      end
      loop_pos = 0;
      cur_slot = 0;
      cmd_q.delete();
    end else begin
      if (out_valid) begin
        if (cmd_q.size() == 0) begin
          report("unexpected word, pattern_index", 32'(out_word.pattern_index), 32'd0);
        end else begin
          e = cmd_q.pop_front();
          if (out_word.command_kind !== e.command_kind)
            report("command_kind", 32'(out_word.command_kind), 32'(e.command_kind));
          if (out_word.target_position !== e.target_position)
            report("target_position", 32'(out_word.target_position),
                   32'(e.target_position));
          if (out_word.interval_ms !== e.interval_ms)
            report("interval_ms", 32'(out_word.interval_ms), 32'(e.interval_ms));
          if (out_word.speed_rate !== e.speed_rate)
            report("speed_rate", 32'(out_word.speed_rate), 32'(e.speed_rate));
          if (out_word.pattern_index !== e.pattern_index)
            report("pattern_index", 32'(out_word.pattern_index), 32'(e.pattern_index));
        end
      end
      if (start && !busy) apply_word(in_word);
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ACTIVE:   run_en <= cfg_data[0];
          CFG_COUNT:    slot_count <= cfg_data;
          CFG_NORMAL:   normal_ok <= cfg_data[0];
          CFG_INTERVAL: interval_ok <= cfg_data[0];
          CFG_SPEED:    speed_ok <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  initial errors = 0;

endmodule

// ----- bench/looping_motion_pattern_sequencer_tb.sv -----
module looping_motion_pattern_sequencer_tb;
  import lmps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 300000;
  localparam int IN_BITS = $bits(in_word_t);

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_word_t   in_word = '0;
  logic       out_valid;
  out_word_t  out_word;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;
  int         errors, pending;
  int         idle_cycles = 0;
  int         max_gap = 10;

  always #4 clk = ~clk;

  looping_motion_pattern_sequencer u_dut (
    .clk, .rst_n, .start, .busy, .in_word, .out_valid, .out_word,
    .cfg_we, .cfg_index, .cfg_data
  );

  looping_motion_pattern_sequencer_chk u_chk (
    .clk, .rst_n, .start, .busy, .in_word, .out_valid, .out_word,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  // watchdog: any accepted word or config write counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_word_t tick_word(logic [15:0] delta);
    in_word_t w;
    w = IN_BITS'({$urandom, $urandom});
    w.cmd = 1'(CMD_TICK);
    w.time_step = delta;
    return w;
  endfunction

  function automatic in_word_t entry_word(logic [3:0] idx, entry_kind_t kind,
                                          logic [15:0] tgt, logic [15:0] dur);
    in_word_t w;
    w = IN_BITS'({$urandom, $urandom});
    w.cmd = 1'(CMD_WRITE);
    w.entry_index = idx;
    w.entry_kind = kind;
    w.entry_target = tgt;
    w.entry_duration = dur;
    return w;
  endfunction

  task automatic send(in_word_t w);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
  endtask

  // drop start, drain expected words, let a silent tick finish
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_target();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_dur();
    case ($urandom_range(0, 39))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return 16'hffff;
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [15:0] rand_delta();
    case ($urandom_range(0, 299))
      0: return 16'hffff;
      1, 2, 3: return 16'd0;
      default: return 16'($urandom_range(0, 120));
    endcase
  endfunction

  initial begin
    logic [4:0] count_set;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: inactive, zero duration, ignored write, single pattern wrap
    send(tick_word(16'd5));
    send(entry_word(4'd0, KIND_SPEED, 16'hffff, 16'd0));
    send(entry_word(4'd1, KIND_NORMAL, 16'd7, 16'd3));
    settle();
    set_reg(CFG_ACTIVE, 5'd1);
    send(tick_word(16'd0));
    send(tick_word(16'd1));
    send(tick_word(16'hffff));
    settle();
    set_reg(CFG_COUNT, 5'd0);
    send(tick_word(16'd3));
    send(entry_word(4'd0, KIND_INTERVAL, 16'd0, 16'hffff));
    send(tick_word(16'hffff));
    settle();
    set_reg(CFG_COUNT, 5'd31);
    send(entry_word(4'd0, KIND_NONE, 16'd0, 16'd2));
    send(entry_word(4'd1, KIND_NORMAL, 16'hffff, 16'd2));
    send(entry_word(4'd2, KIND_INTERVAL, 16'd0, 16'd2));
    send(entry_word(4'd3, KIND_SPEED, 16'hffff, 16'd1));
    send(entry_word(4'd15, KIND_SPEED, 16'd0, 16'd1));
    for (int i = 0; i < 6; i++) send(tick_word(16'd2));
    settle();
    // current entry now beyond the count in use
    set_reg(CFG_COUNT, 5'd3);
    set_reg(CFG_NORMAL, 5'd0);
    set_reg(CFG_INTERVAL, 5'd0);
    set_reg(CFG_SPEED, 5'd0);
    send(tick_word(16'd2));
    send(tick_word(16'd2));
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: count_set = 5'd16;
        1: count_set = 5'd1;
        2: count_set = 5'd2;
        3: count_set = 5'd0;
        4: count_set = 5'd31;
        default: count_set = 5'($urandom_range(0, 31));
      endcase
      set_reg(CFG_ACTIVE, (ph == 6) ? 5'd0 : 5'd1);
      set_reg(CFG_COUNT, count_set);
      set_reg(CFG_NORMAL, (ph == 7) ? 5'd0 : (ph < 3) ? 5'd1 : 5'($urandom));
      set_reg(CFG_INTERVAL, (ph == 7) ? 5'd0 : (ph < 3) ? 5'd1 : 5'($urandom));
      set_reg(CFG_SPEED, (ph == 7) ? 5'd0 : (ph < 3) ? 5'd1 : 5'($urandom));
      max_gap = (ph % 3 == 1) ? 0 : 10;
      for (int i = 0; i < 16; i++)
        send(entry_word(4'(i), entry_kind_t'($urandom_range(0, 3)),
                        rand_target(), rand_dur()));
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 9) == 0)
          send(entry_word(4'($urandom), entry_kind_t'($urandom_range(0, 3)),
                          rand_target(), rand_dur()));
        else
          send(tick_word(rand_delta()));
      end
      settle();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
